// File: rtl/utf8s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types, constants and the lead-byte classifier for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

    localparam logic [7:0] REPL_BYTE   = 8'h3F;  // '?'
    localparam logic [7:0] MASK_2B     = 8'hE0;
    localparam logic [7:0] LEAD_2B     = 8'hC0;
    localparam logic [7:0] MASK_3B     = 8'hF0;
    localparam logic [7:0] LEAD_3B     = 8'hE0;
    localparam logic [7:0] MASK_4B     = 8'hF8;
    localparam logic [7:0] LEAD_4B     = 8'hF0;
    localparam logic [7:0] MASK_CONT   = 8'hC0;
    localparam logic [7:0] CONT_BITS   = 8'h80;
    localparam logic [7:0] MIN_LEAD_2B = 8'hC2;
    localparam logic [7:0] MAX_LEAD_4B = 8'hF4;

    // Input transfer payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // Output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // Group of up to four result bytes produced by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
    } t_cmd;

    // Lead byte class: bad lead, or number of continuation bytes needed
    typedef struct packed {
        logic       bad;
        logic [1:0] extra;
    } t_lead;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_CONT) == CONT_BITS;
    endfunction

    function automatic t_lead classify_lead(input logic [7:0] b);
        t_lead r;
        r.bad   = 1'b0;
        r.extra = 2'd0;
        if (!b[7]) begin
            r.extra = 2'd0;
        end else if ((b & MASK_2B) == LEAD_2B) begin
            r.bad   = (b < MIN_LEAD_2B);
            r.extra = 2'd1;
        end else if ((b & MASK_3B) == LEAD_3B) begin
            r.extra = 2'd2;
        end else if ((b & MASK_4B) == LEAD_4B) begin
            r.bad   = (b > MAX_LEAD_4B);
            r.extra = 2'd3;
        end else begin
            r.bad   = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/utf8s_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_front
// Tracks the pending multi-byte sequence and turns each input byte into a
// group of result bytes for the queue.
// ----------------------------------------------------------------------------
module utf8s_front
    import utf8s_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_data,
    output logic o_push,
    output t_cmd o_cmd
);

    logic [2:0][7:0] r_pend;
    logic [1:0]      r_pcount;
    logic [1:0]      r_need;
    logic [2:0][7:0] n_pend;
    logic [1:0]      n_pcount;
    logic [1:0]      n_need;

    t_cmd  cmd;
    t_lead lead;
    logic  take_lead;
    logic  cont;
    logic [7:0] b;

    always_comb begin
        b         = i_data.in_byte;
        cont      = is_cont(b);
        lead      = classify_lead(b);
        take_lead = 1'b1;
        n_pend    = r_pend;
        n_pcount  = r_pcount;
        n_need    = r_need;
        cmd.bytes = {4{REPL_BYTE}};
        cmd.count = 3'd0;
        cmd.last  = i_data.in_last;

        if (r_pcount != 2'd0) begin
            if (cont) begin
                take_lead = 1'b0;
                if (r_pcount == r_need) begin
                    // sequence complete: pass buffered bytes and this one
                    cmd.bytes[2:0]      = r_pend;
                    cmd.bytes[r_pcount] = b;
                    cmd.count = {1'b0, r_pcount} + 3'd1;
                    n_pcount  = 2'd0;
                    n_need    = 2'd0;
                end else begin
                    n_pend[r_pcount] = b;
                    n_pcount = r_pcount + 2'd1;
                    if (i_data.in_last) begin
                        cmd.count = {1'b0, r_pcount} + 3'd1;
                    end
                end
            end else begin
                // broken sequence: replace every buffered byte
                cmd.count = {1'b0, r_pcount};
                n_pcount  = 2'd0;
                n_need    = 2'd0;
            end
        end

        if (take_lead) begin
            if (lead.bad) begin
                cmd.count = cmd.count + 3'd1;
            end else if (lead.extra == 2'd0) begin
                cmd.bytes[cmd.count[1:0]] = b;
                cmd.count = cmd.count + 3'd1;
            end else if (i_data.in_last) begin
                cmd.count = cmd.count + 3'd1;
            end else begin
                n_pend[0] = b;
                n_pcount  = 2'd1;
                n_need    = lead.extra;
            end
        end

        if (i_data.in_last) begin
            n_pcount = 2'd0;
            n_need   = 2'd0;
        end
    end

    assign o_push = i_accept && (cmd.count != 3'd0);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 2'd0;
            r_need   <= 2'd0;
        end else if (i_accept) begin
            r_pcount <= n_pcount;
            r_need   <= n_need;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

// File: rtl/utf8s_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_queue
// Small FIFO of result groups between the front and back parts.
// ----------------------------------------------------------------------------
module utf8s_queue
    import utf8s_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= wrap_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/utf8s_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_back
// Serializes queued result groups into one output byte per transfer.
// ----------------------------------------------------------------------------
module utf8s_back
    import utf8s_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_data;
    logic       load;
    logic       at_end;

    assign load    = !r_valid || !i_stall;
    assign at_end  = ({1'b0, r_idx} == (i_q_cmd.count - 3'd1));
    assign o_q_pop = load && i_q_valid && at_end;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                // advance within the group, restart on the next one
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_data.out_byte <= i_q_cmd.bytes[r_idx];
            r_data.out_last <= i_q_cmd.last && at_end;
        end
    end

endmodule

// File: rtl/utf8_sanitizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Streaming UTF-8 repair filter: passes well-formed sequences, replaces bad
// lead bytes and broken or truncated sequences with '?'.
// ----------------------------------------------------------------------------
// Every input byte yields exactly one output byte overall, and the block
// sustains one byte per cycle in each direction unless a stall holds it. A
// byte is taken in any cycle the result queue has room; a well-formed
// multi-byte sequence is held back until its final continuation arrives and
// then released as a burst of up to four bytes through the queue and the
// registered output of the serializer. The queue holds QUEUE_DEPTH result
// groups; the output serializer drains one byte per cycle while not stalled
// and sets the pace when bursts pile up. A broken sequence releases one
// '?' per buffered byte and the offending byte is then judged as a new lead.
// in_last closes the string: any open sequence becomes '?' per buffered byte
// and out_last marks the last output byte of that string.
// ----------------------------------------------------------------------------
module utf8_sanitizer
    import utf8s_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input channel
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    // output channel
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic accept;
    t_cmd front_cmd;
    t_cmd head_cmd;

    // Hold the input whenever the queue cannot take another group.
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // Front: classify each byte and track the open sequence.
    utf8s_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // Queue: decouple bursts of results from the one-byte output.
    utf8s_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Back: serialize each group, one byte per output transfer.
    utf8s_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_data    (o_out_data)
    );

endmodule

// File: tb/utf8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_checker
// Watches both channels of the UTF-8 sanitizer, predicts the repaired byte
// stream from every accepted input transfer and compares each output transfer
// against the oldest predicted byte.
// ----------------------------------------------------------------------------
module utf8_checker
    import utf8s_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    input  logic i_final_check,
    output int   o_outstanding,
    output int   o_fail_count
);

    // open sequence: lead plus the continuations seen so far
    logic [7:0] open_seq [3];
    logic [1:0] open_count;
    logic [1:0] open_need;
    t_out       repaired_q [$];
    int         errors     = 0;
    int         expected_n = 0;
    logic       final_done = 1'b0;

    assign o_fail_count  = errors;
    assign o_outstanding = expected_n;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // continuations a lead calls for, -1 for a bad lead
    function automatic int lead_extra(input logic [7:0] b);
        if (!b[7]) return 0;
        if (b[7:5] == 3'b110) return (b >= MIN_LEAD_2B) ? 1 : -1;
        if (b[7:4] == 4'b1110) return 2;
        if (b[7:3] == 5'b11110) return (b <= MAX_LEAD_4B) ? 3 : -1;
        return -1;
    endfunction

    task automatic push_byte(input logic [7:0] v, inout int n);
        t_out entry;
        if (n < 4) begin
            entry.out_byte = v;
            entry.out_last = 1'b0;
            repaired_q.insert(repaired_q.size(), entry);
            n++;
        end
    endtask

    task automatic repair_byte(input t_in item);
        logic [7:0] b;
        logic       take_lead;
        int         extra;
        int         n;
        int         i;
        t_out       tail;
        b         = item.in_byte;
        take_lead = 1'b1;
        n         = 0;
        if (open_count != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                take_lead = 1'b0;
                if (open_count == open_need) begin
                    // final continuation: release the whole sequence
                    for (i = 0; i < open_count; i++) push_byte(open_seq[i], n);
                    push_byte(b, n);
                    open_count = 2'd0;
                    open_need  = 2'd0;
                end else if (open_count < 2'd3) begin
                    open_seq[open_count] = b;
                    open_count = open_count + 2'd1;
                    if (item.in_last) begin
                        for (i = 0; i < open_count; i++) push_byte(REPL_BYTE, n);
                        open_count = 2'd0;
                        open_need  = 2'd0;
                    end
                end else begin
                    for (i = 0; i < 3; i++) push_byte(REPL_BYTE, n);
                    open_count = 2'd0;
                    open_need  = 2'd0;
                    take_lead  = 1'b1;
                end
            end else begin
                // broken sequence: one '?' per buffered byte, then judge b as a lead
                for (i = 0; i < open_count; i++) push_byte(REPL_BYTE, n);
                open_count = 2'd0;
                open_need  = 2'd0;
            end
        end
        if (take_lead) begin
            extra = lead_extra(b);
            if (extra < 0 || (extra > 0 && item.in_last)) begin
                push_byte(REPL_BYTE, n);
            end else if (extra == 0) begin
                push_byte(b, n);
            end else begin
                open_seq[0] = b;
                open_count  = 2'd1;
                open_need   = 2'(extra);
            end
        end
        if (item.in_last) begin
            open_count = 2'd0;
            open_need  = 2'd0;
            if (n > 0) begin
                tail = repaired_q[repaired_q.size() - 1];
                tail.out_last = 1'b1;
                repaired_q[repaired_q.size() - 1] = tail;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            open_count = 2'd0;
            open_need  = 2'd0;
            repaired_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                repair_byte(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (repaired_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                              i_out_data.out_byte, i_out_data.out_last));
                end else begin
                    want = repaired_q.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_out_data.out_byte, want.out_byte));
                    end
                    if (i_out_data.out_last !== want.out_last) begin
                        report_mismatch($sformatf("out_last %0b, expected %0b (byte %02h)",
                                                  i_out_data.out_last, want.out_last,
                                                  want.out_byte));
                    end
                end
            end
            if (i_final_check && !final_done) begin
                final_done = 1'b1;
                if (repaired_q.size() != 0) begin
                    report_mismatch($sformatf("%0d expected bytes never arrived",
                                              repaired_q.size()));
                end
            end
        end
        expected_n = repaired_q.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the UTF-8 sanitizer: directed strings for every
// lead class and failure path, then random strings of mostly well-formed
// characters with noise, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import utf8s_pkg::*;

    localparam int RANDOM_ITEMS     = 440;
    localparam int MAX_IDLE         = 11;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int HOLD_AT_ITEM     = 150;
    localparam int PAUSE_AT_ITEM    = 320;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 20;
    localparam int TIMEOUT_NS       = 1_000_000;

    logic clk         = 1'b0;
    logic rst_n       = 1'b0;
    logic in_valid    = 1'b0;
    logic in_stall;
    t_in  in_data     = '0;
    logic out_valid;
    logic out_stall   = 1'b1;
    t_out out_data;
    logic final_check = 1'b0;
    int   outstanding;
    int   fail_count;

    // bytes of the string being built, sent as one string with in_last at the end
    logic [7:0] text_q [$];
    int         sent_count    = 0;
    int         tx_stretch    = 0;
    logic       tx_busy       = 1'b0;
    // bumped by the stimulus; the receiver serves each bump with one long hold
    int         hold_requests = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utf8_sanitizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    utf8_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_final_check (final_check),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    // Offer one byte. Called at a falling edge; returns at the falling edge after
    // the transfer. Idle phases alternate with stretches of back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (tx_stretch == 0) begin
            tx_busy    = ($urandom_range(0, 3) == 0);
            tx_stretch = $urandom_range(5, 40);
        end
        tx_stretch--;
        gap = tx_busy ? 0 : $urandom_range(0, MAX_IDLE);
        // drop valid only when a gap follows, so valid never toggles within a step
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_last: last};
        // hold the payload until the block takes it
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent_count++;
    endtask

    // Send the built string, in_last on its final byte, and clear it.
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Valid lead for a sequence of len bytes (2..4).
    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return 8'($urandom_range(MIN_LEAD_2B, 8'hDF));
            3:       return 8'($urandom_range(8'hE0, 8'hEF));
            default: return 8'($urandom_range(8'hF0, MAX_LEAD_4B));
        endcase
    endfunction

    // Append one character: mostly well-formed with random content, the rest
    // raw noise, truncated sequences and sequences broken by a non-continuation.
    task automatic add_char();
        int         pick;
        int         len;
        int         keep;
        int         k;
        logic [7:0] breaker;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            text_q.insert(text_q.size(), 8'($urandom_range(0, 127)));
        end else if (pick < 75) begin
            len = (pick < 45) ? 2 : (pick < 60) ? 3 : 4;
            text_q.insert(text_q.size(), lead_byte(len));
            for (k = 1; k < len; k++) text_q.insert(text_q.size(), cont_byte());
        end else if (pick < 85) begin
            text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
        end else begin
            len  = $urandom_range(2, 4);
            keep = $urandom_range(0, len - 2);
            text_q.insert(text_q.size(), lead_byte(len));
            for (k = 0; k < keep; k++) text_q.insert(text_q.size(), cont_byte());
            if (pick >= 93) begin
                // force a non-continuation so the open sequence breaks here
                breaker = 8'($urandom_range(0, 255));
                if (breaker[7:6] == 2'b10) breaker[6] = 1'b1;
                text_q.insert(text_q.size(), breaker);
            end
        end
    endtask

    // Receiver: stall a random number of cycles before each transfer, with
    // stretches of no stall, and serve long-hold requests from the stimulus.
    initial begin
        int   wait_cycles;
        int   holds_done;
        int   rx_stretch;
        logic rx_busy;
        holds_done = 0;
        rx_stretch = 0;
        rx_busy    = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (rx_stretch == 0) begin
                rx_busy    = ($urandom_range(0, 3) == 0);
                rx_stretch = $urandom_range(5, 40);
            end
            rx_stretch--;
            if (holds_done != hold_requests) begin
                // long hold: the result queue fills and the block stalls its input
                holds_done  = hold_requests;
                wait_cycles = LONG_HOLD_CYCLES;
            end else begin
                wait_cycles = rx_busy ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        int   chars;
        int   c;
        int   k;
        int   random_end;
        logic held;
        logic paused;
        held   = 1'b0;
        paused = 1'b0;

        // synchronous reset held low, then released at a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ASCII extremes, stray continuations and the always-bad leads C0, C1, F5, FF
        text_q = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'hC1, 8'hF5, 8'hFF};
        send_text();
        // complete 2-, 3- and 4-byte sequences, the last one closing the string
        text_q = '{8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text();
        // wrong continuation: replay as '?', retake the failing byte as a lead,
        // once as ASCII and once as a new lead that then completes
        text_q = '{8'hE2, 8'h82, 8'h41, 8'hDF, 8'hC3, 8'hA9};
        send_text();
        // end of string inside an open sequence
        text_q = '{8'hF0, 8'h90};
        send_text();
        // multi-byte lead arriving as the last byte
        text_q = '{8'hC3};
        send_text();

        random_end = sent_count + RANDOM_ITEMS;
        while (sent_count < random_end) begin
            if (!held && sent_count >= random_end - RANDOM_ITEMS + HOLD_AT_ITEM) begin
                // keep offering back-to-back while the receiver holds off
                held          = 1'b1;
                hold_requests = hold_requests + 1;
                tx_busy       = 1'b1;
                tx_stretch    = 60;
            end
            if (!paused && sent_count >= random_end - RANDOM_ITEMS + PAUSE_AT_ITEM) begin
                // pause at a string boundary until every expected byte is out
                paused = 1'b1;
                in_valid <= 1'b0;
                do @(negedge clk); while (outstanding != 0);
            end
            chars = $urandom_range(1, 8);
            for (c = 0; c < chars; c++) add_char();
            send_text();
        end

        in_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && outstanding != 0; k++) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        final_check <= 1'b1;
        repeat (2) @(negedge clk);

        if (fail_count == 0) begin
            $display("** utf8_sanitizer: PASSED **");
        end else begin
            $display("** utf8_sanitizer: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("** utf8_sanitizer: FAILED **");
        $finish;
    end

endmodule
